FILE: rtl/core/ott_pkg.sv
// Shared types and constants of the ordered timer table.
package ott_pkg;

  localparam int NOW_W      = 48;
  localparam int PER_W      = 32;
  localparam int DL_W       = 49;
  localparam int MAX_EXPIRE = 16;
  localparam int CNT_W      = 5;

  localparam logic [2:0] REQ_ADD    = 3'd0;
  localparam logic [2:0] REQ_RESET  = 3'd1;
  localparam logic [2:0] REQ_DELETE = 3'd2;
  localparam logic [2:0] REQ_EXPIRE = 3'd3;
  localparam logic [2:0] REQ_QUERY  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_INV_PER   = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_FREE, S_WRITE, S_SCAN, S_TAIL, S_POST, S_FLUSH, S_RESULT
  } state_t;

  typedef enum logic [1:0] {RET_IDLE, RET_SCAN, RET_FLUSH} ret_t;

  // Ordering key: deadline first, then period.
  typedef struct packed {
    logic [DL_W-1:0]  deadline;
    logic [PER_W-1:0] period;
  } key_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [3:0]       slot;
    logic             front;
    logic             expired;
    logic             action;
    logic             empty;
    logic [PER_W-1:0] delay;
    logic             last;
  } res_t;

endpackage

FILE: rtl/core/ott_min_unit.sv
// Running minimum over streamed timer entries, lowest slot wins a tie.
module ott_min_unit #(
  parameter int IW = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            clr,
  input  logic            en,
  input  logic [IW-1:0]   slot,
  input  ott_pkg::key_t   key,
  output logic            found,
  output logic [IW-1:0]   best_slot,
  output ott_pkg::key_t   best_key
);

  logic take;

  // Strict compare: entries arrive in ascending slot order.
  assign take = en && (!found || (key < best_key));

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_slot <= slot;
      best_key  <= key;
    end
  end

endmodule

FILE: rtl/core/ordered_timer_table.sv
// Top level of the ordered timer table: slot store, scan sequencer and output register.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------------------
//  request | in        | in_valid / in_stall        | req_type slot_id period_ms recurrent
//          |           |                            | has_action now_ms tick_pending
//  result  | out       | out_valid / out_stall      | status result_slot front_event
//          |           |                            | expired_valid action_valid table_empty
//          |           |                            | next_delay last
//
// Each request walks the slot store once per minimum search, one slot per cycle through
// a single read port and one shared key comparator.
// Add: a free-slot search, then one write and one search; a full table ends after the free-slot search.
// Reset and query: one search; delete and rejects: no search.
// Expire: one search per due timer, at most 16 of them, plus one final search unless
// the cap is reached.
// in_stall is high from acceptance until the last result enters the output register;
// a stalled output holds the sequencer. Reset is synchronous and needs no clearing pass.
module ordered_timer_table #(
  parameter int NUM_TIMERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [3:0]  slot_id,
  input  logic [31:0] period_ms,
  input  logic        recurrent,
  input  logic        has_action,
  input  logic [47:0] now_ms,
  input  logic        tick_pending,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [3:0]  result_slot,
  output logic        front_event,
  output logic        expired_valid,
  output logic        action_valid,
  output logic        table_empty,
  output logic [31:0] next_delay,
  output logic        last
);

  localparam int IW = $clog2(NUM_TIMERS);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

  ott_pkg::state_t state, state_next;

  // Latched request
  logic [2:0]                  req_q;
  logic [3:0]                  sid_q;
  logic [ott_pkg::PER_W-1:0]   per_q;
  logic                        rec_q;
  logic                        act_q;
  logic [ott_pkg::NOW_W-1:0]   now_q;
  logic                        tick_q;

  // Slot state: flags in flops, keys in a memory
  logic [NUM_TIMERS-1:0] valid_bits;
  logic [NUM_TIMERS-1:0] rec_bits;
  logic [NUM_TIMERS-1:0] act_bits;
  logic [NUM_TIMERS-1:0] taken;
  ott_pkg::key_t         mem [NUM_TIMERS];

  // Scan pipeline
  logic [IW-1:0]  idx;
  logic           rd_vld_q;
  logic [IW-1:0]  rd_idx_q;
  ott_pkg::key_t  rd_key;

  logic [IW-1:0]  slot_reg;
  logic [ott_pkg::CNT_W-1:0] exp_n;
  logic           pend_vld;
  logic [IW-1:0]  pend_slot;
  logic           pend_act;

  ott_pkg::res_t  res, res_next, out_q;
  ott_pkg::ret_t  ret, ret_next;

  logic           in_acc, out_free, out_load;
  logic [IW-1:0]  sid_idx;
  logic           sid_ok, is_exp, due, scan_en, scan_clr, cap;
  logic [ott_pkg::CNT_W-1:0] n_new;
  logic           found;
  logic [IW-1:0]  best_slot;
  ott_pkg::key_t  best_key;
  logic           mem_we;
  logic [IW-1:0]  mem_waddr;
  logic [ott_pkg::PER_W-1:0] add_b;
  ott_pkg::key_t  mem_wdata;
  logic [ott_pkg::DL_W-1:0]  diff;
  logic [ott_pkg::PER_W-1:0] delay;

  assign in_stall = (state != ott_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == ott_pkg::S_RESULT) && out_free;

  assign sid_idx = IW'(sid_q);
  assign sid_ok  = (32'(sid_q) < NUM_TIMERS) && valid_bits[sid_idx];
  assign is_exp  = (req_q == ott_pkg::REQ_EXPIRE);
  assign due     = rd_key.deadline <= ott_pkg::DL_W'(now_q);
  // Expire looks only at due timers not yet handled in this request.
  assign scan_en = rd_vld_q && valid_bits[rd_idx_q] &&
                   (!is_exp || (!taken[rd_idx_q] && due));
  assign scan_clr = (state == ott_pkg::S_SCAN) && (idx == '0);
  assign n_new   = exp_n + 1'b1;
  assign cap     = (n_new == ott_pkg::CNT_W'(ott_pkg::MAX_EXPIRE));

  ott_min_unit #(.IW(IW)) u_min (
    .clk       (clk),
    .rst       (rst),
    .clr       (scan_clr),
    .en        (scan_en),
    .slot      (rd_idx_q),
    .key       (rd_key),
    .found     (found),
    .best_slot (best_slot),
    .best_key  (best_key)
  );

  // Remaining delay to the earliest deadline, saturated to 32 bits.
  assign diff = best_key.deadline - ott_pkg::DL_W'(now_q);
  always_comb begin
    if (best_key.deadline <= ott_pkg::DL_W'(now_q)) begin
      delay = '0;
    end else if (|diff[ott_pkg::DL_W-1:ott_pkg::PER_W]) begin
      delay = '1;
    end else begin
      delay = diff[ott_pkg::PER_W-1:0];
    end
  end

  // Shared arm adder: add/reset write the request period, expire re-arms a recurrent timer.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = best_slot;
    add_b     = best_key.period;
    if (state == ott_pkg::S_WRITE) begin
      mem_we    = 1'b1;
      mem_waddr = slot_reg;
      add_b     = per_q;
    end else if ((state == ott_pkg::S_POST) && is_exp && found && rec_bits[best_slot]) begin
      mem_we    = 1'b1;
    end
    mem_wdata.deadline = ott_pkg::DL_W'(now_q) + ott_pkg::DL_W'(add_b);
    mem_wdata.period   = add_b;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ott_pkg::S_IDLE: begin
        if (in_acc) state_next = ott_pkg::S_DECODE;
      end
      ott_pkg::S_DECODE: begin
        case (req_q)
          ott_pkg::REQ_ADD: state_next = ott_pkg::S_FREE;
          ott_pkg::REQ_RESET: begin
            if ((per_q == '1) || !sid_ok) state_next = ott_pkg::S_RESULT;
            else state_next = ott_pkg::S_WRITE;
          end
          ott_pkg::REQ_EXPIRE, ott_pkg::REQ_QUERY: state_next = ott_pkg::S_SCAN;
          default: state_next = ott_pkg::S_RESULT;
        endcase
      end
      ott_pkg::S_FREE: begin
        if (!valid_bits[idx]) state_next = ott_pkg::S_WRITE;
        else if (idx == LAST_IDX) state_next = ott_pkg::S_RESULT;
      end
      ott_pkg::S_WRITE: state_next = ott_pkg::S_SCAN;
      ott_pkg::S_SCAN: begin
        if (idx == LAST_IDX) state_next = ott_pkg::S_TAIL;
      end
      ott_pkg::S_TAIL: state_next = ott_pkg::S_POST;
      ott_pkg::S_POST: begin
        if (is_exp && found && !pend_vld) begin
          state_next = cap ? ott_pkg::S_FLUSH : ott_pkg::S_SCAN;
        end else begin
          state_next = ott_pkg::S_RESULT;
        end
      end
      ott_pkg::S_FLUSH: state_next = ott_pkg::S_RESULT;
      ott_pkg::S_RESULT: begin
        if (out_free) begin
          case (ret)
            ott_pkg::RET_SCAN:  state_next = ott_pkg::S_SCAN;
            ott_pkg::RET_FLUSH: state_next = ott_pkg::S_FLUSH;
            default:            state_next = ott_pkg::S_IDLE;
          endcase
        end
      end
      default: state_next = ott_pkg::S_IDLE;
    endcase
  end

  // Result staging and where to go after it leaves
  always_comb begin
    res_next      = '0;
    res_next.last = 1'b1;
    ret_next      = ott_pkg::RET_IDLE;
    case (state)
      ott_pkg::S_DECODE: begin
        if (req_q == ott_pkg::REQ_RESET) begin
          if (per_q == '1) res_next.status = ott_pkg::ST_INV_PER;
          else if (!sid_ok) res_next.status = ott_pkg::ST_NOT_FOUND;
        end else if (req_q == ott_pkg::REQ_DELETE) begin
          if (!sid_ok) res_next.status = ott_pkg::ST_NOT_FOUND;
        end
      end
      ott_pkg::S_FREE: res_next.status = ott_pkg::ST_FULL;
      ott_pkg::S_POST: begin
        case (req_q)
          ott_pkg::REQ_ADD: begin
            res_next.slot  = 4'(slot_reg);
            res_next.front = found && (best_slot == slot_reg) && !tick_q;
          end
          ott_pkg::REQ_RESET: begin
            res_next.front = found && (best_slot == slot_reg) && !tick_q;
          end
          ott_pkg::REQ_QUERY: begin
            res_next.empty = !found;
            res_next.delay = found ? delay : '0;
          end
          ott_pkg::REQ_EXPIRE: begin
            if (pend_vld) begin
              // Previous due timer goes out; last only if nothing else was found.
              res_next.slot    = 4'(pend_slot);
              res_next.expired = 1'b1;
              res_next.action  = pend_act;
              res_next.last    = !found;
              if (found) ret_next = cap ? ott_pkg::RET_FLUSH : ott_pkg::RET_SCAN;
            end
          end
          default: ;
        endcase
      end
      ott_pkg::S_FLUSH: begin
        res_next.slot    = 4'(pend_slot);
        res_next.expired = 1'b1;
        res_next.action  = pend_act;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ott_pkg::S_IDLE;
      valid_bits <= '0;
      rd_vld_q   <= 1'b0;
      pend_vld   <= 1'b0;
      exp_n      <= '0;
      out_valid  <= 1'b0;
      ret        <= ott_pkg::RET_IDLE;
    end else begin
      state    <= state_next;
      rd_vld_q <= (state == ott_pkg::S_SCAN);
      if (state != ott_pkg::S_RESULT && state_next == ott_pkg::S_RESULT) ret <= ret_next;
      case (state)
        ott_pkg::S_DECODE: begin
          if (req_q == ott_pkg::REQ_DELETE && sid_ok) valid_bits[sid_idx] <= 1'b0;
          if (is_exp) begin
            pend_vld <= 1'b0;
            exp_n    <= '0;
          end
        end
        ott_pkg::S_WRITE: valid_bits[slot_reg] <= 1'b1;
        ott_pkg::S_POST: begin
          if (is_exp && found) begin
            // Free one-shot timers; recurrent ones are re-armed through the memory.
            if (!rec_bits[best_slot]) valid_bits[best_slot] <= 1'b0;
            pend_vld <= 1'b1;
            exp_n    <= n_new;
          end
        end
        default: ;
      endcase
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_q  <= req_type;
      sid_q  <= slot_id;
      per_q  <= period_ms;
      rec_q  <= recurrent;
      act_q  <= has_action;
      now_q  <= now_ms;
      tick_q <= tick_pending;
    end
    if (state != state_next) idx <= '0;
    else if (state == ott_pkg::S_SCAN || state == ott_pkg::S_FREE) idx <= idx + 1'b1;
    case (state)
      ott_pkg::S_DECODE: begin
        slot_reg <= sid_idx;
        if (is_exp) taken <= '0;
      end
      ott_pkg::S_FREE: slot_reg <= idx;
      ott_pkg::S_WRITE: begin
        rec_bits[slot_reg] <= rec_q;
        if (req_q == ott_pkg::REQ_ADD) act_bits[slot_reg] <= act_q;
      end
      ott_pkg::S_POST: begin
        if (is_exp && found) begin
          taken[best_slot] <= 1'b1;
          pend_slot        <= best_slot;
          pend_act         <= act_bits[best_slot];
        end
      end
      default: ;
    endcase
    if (state != ott_pkg::S_RESULT && state_next == ott_pkg::S_RESULT) res <= res_next;
    if (out_load) out_q <= res;
  end

  // Key memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_key   <= mem[idx];
    rd_idx_q <= idx;
  end

  assign status        = out_q.status;
  assign result_slot   = out_q.slot;
  assign front_event   = out_q.front;
  assign expired_valid = out_q.expired;
  assign action_valid  = out_q.action;
  assign table_empty   = out_q.empty;
  assign next_delay    = out_q.delay;
  assign last          = out_q.last;

`ifndef NO_ASSERTIONS
  a_load_fills: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("result register not filled after load");

  a_exp_cap: assert property (@(posedge clk) disable iff (rst)
    exp_n <= ott_pkg::CNT_W'(ott_pkg::MAX_EXPIRE))
    else $error("expire count beyond cap");

  a_exp_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_q.expired |-> out_q.status == ott_pkg::ST_OK)
    else $error("expired item with error status");

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == ott_pkg::S_DECODE)
    else $error("accepted item not decoded");
`endif

endmodule
